FILE: hdl/mrt_pkg.sv
// Shared types and constants of the mapped region table.
package mrt_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int PAGE_DEF = 4096;

  localparam logic [1:0] ACT_MAP = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_PROTECT = 2'd2;
  localparam logic [1:0] ACT_LOOKUP = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BADARG = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_BADHANDLE = 3'd5;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic signed [8:0] NO_FILE = -9'sd1;

  // one stored region
  typedef struct packed {
    logic used;
    logic [31:0] base;
    logic [31:0] len;
    logic [3:0] flags;
    logic [2:0] prot;
    logic signed [8:0] file;
    logic [31:0] foff;
  } region_t;

  // one beat that travels the chain of cells
  typedef struct packed {
    logic valid;
    logic [1:0] op;         // CELL_* code
    logic [32:0] va;        // candidate start or probe address
    logic [32:0] len;       // rounded length, 1 for a point probe or 0 for an empty probe
    logic hit;              // first match found
    logic free_found;       // a free slot was seen
    logic moved;            // candidate moved this pass
    region_t hit_reg;       // copy of the matching region
    logic [32:0] rend;      // end of first overlapping region
  } probe_t;

  localparam logic [1:0] CELL_CONTAIN = 2'd0;  // find containing region
  localparam logic [1:0] CELL_OVERLAP = 2'd1;  // find first overlapping region
  localparam logic [1:0] CELL_WRITE = 2'd2;    // write first free slot
  localparam logic [1:0] CELL_UPDATE = 2'd3;   // rewrite the first container

  // edit applied by the update pass
  typedef struct packed {
    logic [1:0] kind;       // EDIT_* code
    logic [31:0] addr;
    logic [31:0] len;
    logic [2:0] prot;
  } edit_t;

  localparam logic [1:0] EDIT_FREE = 2'd0;
  localparam logic [1:0] EDIT_TRIM = 2'd1;
  localparam logic [1:0] EDIT_CUT = 2'd2;
  localparam logic [1:0] EDIT_PROT = 2'd3;
endpackage

FILE: hdl/mrt_cell.sv
// One slot of the region table; checks and edits the beat passing through.
module mrt_cell
  import mrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  probe_t pin,
  input  region_t wdata,
  input  edit_t edit,
  output probe_t pout
);
  region_t r;
  region_t r_next;
  probe_t p;
  logic [32:0] rend;
  logic contains;
  logic overlap;

  always_comb begin
    rend = {1'b0, r.base} + {1'b0, r.len};
    contains = r.used && ({1'b0, r.base} <= pin.va) && (pin.va + pin.len <= rend);
    overlap = r.used && (pin.va < rend) && (pin.va + pin.len > {1'b0, r.base});
    p = pin;
    r_next = r;
    if (pin.valid && !pin.hit) begin
      case (pin.op)
        CELL_CONTAIN: begin
          if (contains) begin
            p.hit = 1'b1;
            p.hit_reg = r;
          end
        end
        CELL_OVERLAP: begin
          if (overlap) begin
            p.hit = 1'b1;
            p.rend = rend;
          end
          if (!r.used) p.free_found = 1'b1;
        end
        CELL_WRITE: begin
          if (!r.used) begin
            p.hit = 1'b1;
            r_next = wdata;
          end
        end
        CELL_UPDATE: begin
          if (contains) begin
            p.hit = 1'b1;
            case (edit.kind)
              EDIT_FREE: begin
                r_next.used = 1'b0;
                r_next.file = NO_FILE;
              end
              EDIT_TRIM: begin
                r_next.base = r.base + edit.len;
                r_next.len = r.len - edit.len;
                r_next.foff = r.foff + edit.len;
              end
              EDIT_CUT: r_next.len = edit.addr - r.base;
              default: r_next.prot = edit.prot;
            endcase
            p.hit_reg = r_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r.used <= 1'b0;
      r.file <= NO_FILE;
      pout.valid <= 1'b0;
    end else begin
      r.used <= r_next.used;
      r.file <= r_next.file;
      pout.valid <= p.valid;
    end
    r.base <= r_next.base;
    r.len <= r_next.len;
    r.flags <= r_next.flags;
    r.prot <= r_next.prot;
    r.foff <= r_next.foff;
    pout.op <= p.op;
    pout.va <= p.va;
    pout.len <= p.len;
    pout.hit <= p.hit;
    pout.free_found <= p.free_found;
    pout.moved <= p.moved;
    pout.hit_reg <= p.hit_reg;
    pout.rend <= p.rend;
  end
endmodule

FILE: hdl/mapped_region_table_top.sv
// Top level of the mapped region table: control sequencer and the chain of slot cells.
//
// The block keeps REGION_SLOTS regions, one in each cell of a chain. Every
// pass over the table sends one beat down the chain, one cell per cycle.
// Lookup, protect and unmap take one search pass (protect and unmap a second
// pass to edit the slot); a map with a fixed hint takes a free-slot check pass
// and a write pass; a searching map takes one pass per overlapping region it
// skips, a last scan pass and the write pass. So an item costs about 1 to
// (k + 2) passes, where k is the number of regions skipped. One item is in
// the chain at a time; the result register holds the finished beat until
// taken, and the next item is accepted only after that. After reset all slots
// read as free; no clearing pass.
module mapped_region_table_top
  import mrt_pkg::*;
#(
  parameter int REGION_SLOTS = SLOTS_DEF,
  parameter int PAGE_BYTES = PAGE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] action,
  input  logic [31:0] address,
  input  logic [31:0] length,
  input  logic [3:0] map_flags,
  input  logic [2:0] protection,
  input  logic signed [8:0] file_handle,
  input  logic [31:0] file_offset,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] status,
  output logic [31:0] region_address,
  output logic [31:0] region_size,
  output logic [2:0] region_protection,
  output logic signed [8:0] region_file,
  output logic [31:0] page_file_offset,
  output logic [2:0] pte_flags,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int PB = $clog2(PAGE_BYTES);
  localparam logic [32:0] PMASK = 33'((1 << PB) - 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_PASS, S_WAIT, S_DONE} state_t;

  state_t state;
  logic [31:0] area_start;
  logic [31:0] area_limit;
  logic [31:0] search_base;

  // held item
  logic [1:0] op;
  logic [31:0] addr;
  logic [32:0] rlen;
  logic [3:0] mflags;
  logic [2:0] prot;
  logic signed [8:0] fd;
  logic [31:0] foff;
  logic [32:0] va;
  logic length_zero;   // zero length held with the item
  logic [1:0] ekind;   // edit chosen from the containing region

  probe_t chain [REGION_SLOTS+1];
  probe_t launch;
  region_t wdata;
  edit_t edit;

  logic [32:0] in_rlen;
  assign in_rlen = ({1'b0, length} + PMASK) & ~PMASK;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE) || out_valid;

  genvar g;
  generate
    for (g = 0; g < REGION_SLOTS; g++) begin : g_cell
      mrt_cell u_cell (
        .clk(clk), .rst(rst), .pin(chain[g]), .wdata(wdata), .edit(edit),
        .pout(chain[g+1])
      );
    end
  endgenerate
  assign chain[0] = launch;

  probe_t res;
  assign res = chain[REGION_SLOTS];

  always_comb begin
    wdata.used = 1'b1;
    wdata.base = va[31:0];
    wdata.len = rlen[31:0];
    wdata.flags = mflags;
    wdata.prot = prot;
    wdata.file = mflags[2] ? NO_FILE : fd;
    wdata.foff = foff;
    edit.kind = ekind;
    edit.addr = addr;
    edit.len = rlen[31:0];
    edit.prot = prot;
  end

  logic [32:0] va_end;
  assign va_end = va + rlen;
  logic [31:0] page;
  assign page = {addr[31:PB], PB'(0)};

  // launch a pass with the given op
  function automatic probe_t mk(input logic [1:0] c, input logic [32:0] a,
                                input logic [32:0] l);
    probe_t p;
    p = '0;
    p.valid = 1'b1;
    p.op = c;
    p.va = a;
    p.len = l;
    return p;
  endfunction

  task automatic finish(input logic [2:0] st);
    state <= S_DONE;
    status <= st;
    region_address <= '0;
    region_size <= '0;
    region_protection <= '0;
    region_file <= '0;
    page_file_offset <= '0;
    pte_flags <= '0;
  endtask

  always_ff @(posedge clk) begin
    probe_t launch_v;
    // the launch beat is valid for one cycle only
    launch_v = launch;
    launch_v.valid = 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      area_start <= 32'h4000_0000;
      area_limit <= 32'hC000_0000;
      search_base <= 32'h4000_0000;
      launch <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == CFG_START) begin
          area_start <= cfg_data;
          search_base <= cfg_data;
        end else begin
          area_limit <= cfg_data;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op <= action;
            addr <= address;
            rlen <= in_rlen;
            mflags <= map_flags;
            prot <= protection;
            fd <= file_handle;
            foff <= file_offset;
            length_zero <= (length == '0);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (op == ACT_LOOKUP) begin
            launch_v = mk(CELL_CONTAIN, {1'b0, addr}, 33'd1);
            state <= S_WAIT;
          end else if (length_zero || (op == ACT_MAP && mflags[1:0] == 2'b00) ||
                       (op != ACT_PROTECT && rlen[32]) ||
                       (op != ACT_MAP && addr[PB-1:0] != '0)) begin
            finish(ST_BADARG);
          end else if (op == ACT_PROTECT) begin
            launch_v = mk(CELL_CONTAIN, {1'b0, addr}, 33'd1);
            state <= S_WAIT;
          end else if (op == ACT_UNMAP) begin
            launch_v = mk(CELL_CONTAIN, {1'b0, addr}, rlen);
            state <= S_WAIT;
          end else if (mflags[3] && addr != '0) begin
            if (addr[PB-1:0] != '0 || ({1'b0, addr} + rlen) > 33'h1_0000_0000) begin
              finish(ST_BADARG);
            end else begin
              va <= {1'b0, addr};
              state <= S_PASS;
            end
          end else begin
            va <= ({1'b0, search_base} + PMASK) & ~PMASK;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          // map pass: limit check for searching maps, then scan; a fixed hint
          // sends an empty probe that only looks for a free slot
          if (!(mflags[3] && addr != '0) && va_end > {1'b0, area_limit}) begin
            finish(ST_NOSPACE);
          end else begin
            launch_v = mk(CELL_OVERLAP, (mflags[3] && addr != '0) ? 33'd0 : va,
                          (mflags[3] && addr != '0) ? 33'd0 : rlen);
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (res.valid) begin
            case (res.op)
              CELL_CONTAIN: begin
                if (!res.hit) finish(ST_NOTFOUND);
                else if (op == ACT_LOOKUP) begin
                  state <= S_DONE;
                  status <= ST_OK;
                  region_address <= res.hit_reg.base;
                  region_size <= res.hit_reg.len;
                  region_protection <= res.hit_reg.prot;
                  region_file <= res.hit_reg.file;
                  page_file_offset <= res.hit_reg.file[8] ? 32'd0 :
                      res.hit_reg.foff + (page - res.hit_reg.base);
                  pte_flags <= {1'b1, res.hit_reg.prot[1], 1'b1};
                end else begin
                  launch_v = mk(CELL_UPDATE, {1'b0, addr},
                                (op == ACT_PROTECT) ? 33'd1 : rlen);
                  // hold the edit for the whole update pass
                  if (op == ACT_PROTECT) ekind <= EDIT_PROT;
                  else if (res.hit_reg.base == addr && rlen[31:0] >= res.hit_reg.len)
                    ekind <= EDIT_FREE;
                  else if (res.hit_reg.base == addr) ekind <= EDIT_TRIM;
                  else ekind <= EDIT_CUT;
                end
              end
              CELL_UPDATE: begin
                state <= S_DONE;
                status <= ST_OK;
                if (op == ACT_PROTECT) begin
                  region_address <= res.hit_reg.base;
                  region_size <= res.hit_reg.len;
                  region_protection <= prot;
                  region_file <= res.hit_reg.file;
                  page_file_offset <= '0;
                  pte_flags <= {1'b1, prot[1], 1'b1};
                end else begin
                  region_address <= addr;
                  region_size <= rlen[31:0];
                  region_protection <= '0;
                  region_file <= '0;
                  page_file_offset <= '0;
                  pte_flags <= '0;
                end
              end
              CELL_OVERLAP: begin
                if (res.hit) begin
                  // skip past the overlapping region and rescan
                  va <= (res.rend + PMASK) & ~PMASK;
                  state <= S_PASS;
                end else if (!res.free_found) begin
                  finish(ST_FULL);
                end else if (!mflags[2] && fd[8]) begin
                  finish(ST_BADHANDLE);
                end else begin
                  launch_v = mk(CELL_WRITE, va, rlen);
                end
              end
              default: begin
                // write pass done
                state <= S_DONE;
                status <= ST_OK;
                region_address <= va[31:0];
                region_size <= rlen[31:0];
                region_protection <= prot;
                region_file <= mflags[2] ? NO_FILE : fd;
                page_file_offset <= foff;
                pte_flags <= {1'b1, prot[1], 1'b1};
                if (va_end > {1'b0, search_base})
                  search_base <= va_end[32] ? 32'hFFFF_FFFF : va_end[31:0];
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      launch <= launch_v;
    end
  end
endmodule
